[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the escape-time unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[design/mbrot_pkg.sv]
// ----------------------------------------------------------------------------
// mbrot_pkg
// Types, register codes and widths shared by the escape-time unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbrot_pkg;

   localparam int FRAC_BITS = 28;
   localparam int CRD_W     = 10;
   localparam int FIX_W     = 32;
   localparam int PROD_W    = 2 * FIX_W;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 32;
   localparam int IDX_W     = 3;

   localparam logic [IDX_W-1:0] CSR_MIN_RE   = 3'd0;
   localparam logic [IDX_W-1:0] CSR_MIN_IM   = 3'd1;
   localparam logic [IDX_W-1:0] CSR_STEP_RE  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_STEP_IM  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_MAX_ITER = 3'd4;

   localparam logic [FIX_W-1:0] MIN_RE_RST   = 32'hE000_0000;
   localparam logic [FIX_W-1:0] MIN_IM_RST   = 32'hECCC_CCCD;
   localparam logic [FIX_W-1:0] STEP_RE_RST  = 32'h000C_0000;
   localparam logic [FIX_W-1:0] STEP_IM_RST  = 32'h0009_999A;
   localparam logic [CRD_W-1:0] MAX_ITER_RST = 10'd50;

   typedef struct packed {
      logic [FIX_W-1:0] min_re;
      logic [FIX_W-1:0] min_im;
      logic [FIX_W-1:0] step_re;
      logic [FIX_W-1:0] step_im;
      logic [CRD_W-1:0] max_iter;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic init;
      logic mul;
      logic update;
      logic escape;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic at_limit;
      logic escape_hit;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[design/mandelbrot_escape_time_unit.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time evaluator: one pixel coordinate in, iteration count out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel beat (col, row). The pixel maps to
//   c = min + index * step in signed Q4.28, and z = z*z + c runs from z = 0
//   until |z|^2 reaches 4.0 or the count reaches max_iter.
//   rsp_* returns col, row, the iteration count and the escape flag.
//   csr_* writes one register per beat (index 0..4: min_re, min_im, step_re,
//   step_im, max_iter); other indexes are dropped. csr_ready is always high.
//   Write registers only while no pixel is in flight.
// Timing:
//   Each iteration is a product step (three 32x32 multipliers), then a
//   test/update step. A pixel passes load, set-up of c, the iterations and
//   the emit step; the next pixel is taken at the earliest in the cycle in
//   which its result beat shows.
// Reset:
//   Synchronous, active high; registers return to their default view, the
//   sequencer goes idle and no result beat is shown.
// Stall:
//   A finished result waits in the output register while the next pixel is
//   taken; a further result holds the unit until rsp_tready drains the first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // req_tdata: col[9:0], row[19:10], zero pad [23:20]
   input  wire logic [mbrot_pkg::REQ_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // rsp_tdata: out_col[9:0], out_row[19:10], iter_count[29:20], escaped[30],
   // zero pad [31]
   output logic [mbrot_pkg::RSP_W-1:0]      rsp_tdata,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [mbrot_pkg::IDX_W-1:0] csr_index,
   input  wire logic [mbrot_pkg::FIX_W-1:0] csr_data
);
   import mbrot_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_re   <= MIN_RE_RST;
         cfg_ff.min_im   <= MIN_IM_RST;
         cfg_ff.step_re  <= STEP_RE_RST;
         cfg_ff.step_im  <= STEP_IM_RST;
         cfg_ff.max_iter <= MAX_ITER_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_RE:   cfg_ff.min_re   <= csr_data;
            CSR_MIN_IM:   cfg_ff.min_im   <= csr_data;
            CSR_STEP_RE:  cfg_ff.step_re  <= csr_data;
            CSR_STEP_IM:  cfg_ff.step_im  <= csr_data;
            CSR_MAX_ITER: cfg_ff.max_iter <= csr_data[CRD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mbrot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mbrot_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[design/mbrot_ctrl.sv]
// ----------------------------------------------------------------------------
// mbrot_ctrl
// Sequencer: accept a pixel, set up c, run test/update iterations, emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbrot_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire mbrot_pkg::sts_type sts,
   output mbrot_pkg::cmd_type     cmd
);
   import mbrot_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_COORD = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_CHK   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_COORD;
            end
         end
         ST_COORD: begin
            cmd.init = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // limit checked before every iteration
            if (sts.at_limit) begin
               state_in = ST_FIN;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (sts.escape_hit) begin
               cmd.escape = 1'b1;
               state_in   = ST_FIN;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_FIN: begin
            // hold until the output register frees up
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/mbrot_dpath.sv]
// ----------------------------------------------------------------------------
// mbrot_dpath
// Coordinate mapping, Q4.28 z = z*z + c datapath and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mbrot_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mbrot_pkg::cfg_type          cfg,
   input  wire mbrot_pkg::cmd_type          cmd,
   output mbrot_pkg::sts_type               sts,
   // req_tdata: col[9:0], row[19:10], zero pad [23:20]
   input  wire logic [mbrot_pkg::REQ_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // rsp_tdata: out_col[9:0], out_row[19:10], iter_count[29:20], escaped[30],
   // zero pad [31]
   output logic [mbrot_pkg::RSP_W-1:0]      rsp_tdata
);
   import mbrot_pkg::*;

   logic        [CRD_W-1:0]  col_ff, row_ff;
   logic        [FIX_W-1:0]  cr_ff, ci_ff;
   logic signed [FIX_W-1:0]  zr_ff, zi_ff;
   logic        [CRD_W-1:0]  count_ff;
   logic                     esc_ff;
   logic        [PROD_W-1:0] rr_ff, ii_ff, ri_ff;

   logic        [CRD_W-1:0]  out_col_ff, out_row_ff, out_cnt_ff;
   logic                     out_esc_ff;
   logic                     rsp_valid_ff;

   logic        [FIX_W-1:0]     cr_prod, ci_prod;
   logic        [FIX_W-1:0]     cr_in, ci_in, zr_in, zi_in;
   logic        [PROD_W-1:0]    mag_sq;

   // c = min + index * step, wrapped to 32 bits; the low 32 bits of the
   // product do not depend on the sign of step
   assign cr_prod = cfg.step_re * FIX_W'(col_ff);
   assign ci_prod = cfg.step_im * FIX_W'(row_ff);
   assign cr_in   = cfg.min_re + cr_prod;
   assign ci_in   = cfg.min_im + ci_prod;

   // both squares are non-negative and at most 2^62, so the sum cannot wrap
   assign mag_sq = rr_ff + ii_ff;

   assign zr_in = rr_ff[FRAC_BITS+FIX_W-1:FRAC_BITS]
                - ii_ff[FRAC_BITS+FIX_W-1:FRAC_BITS] + cr_ff;
   assign zi_in = ri_ff[FRAC_BITS+FIX_W-2:FRAC_BITS-1] + ci_ff;

   assign sts.at_limit   = (count_ff == cfg.max_iter);
   assign sts.escape_hit = |mag_sq[PROD_W-1:2*FRAC_BITS+2];
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= req_tdata[CRD_W-1:0];
         row_ff <= req_tdata[2*CRD_W-1:CRD_W];
      end
      if (cmd.init) begin
         cr_ff    <= cr_in;
         ci_ff    <= ci_in;
         zr_ff    <= '0;
         zi_ff    <= '0;
         count_ff <= '0;
         esc_ff   <= 1'b0;
      end
      if (cmd.mul) begin
         // sign-extended operands: a 32x32 signed product in 64 bits
         rr_ff <= PROD_W'(zr_ff) * PROD_W'(zr_ff);
         ii_ff <= PROD_W'(zi_ff) * PROD_W'(zi_ff);
         ri_ff <= PROD_W'(zr_ff) * PROD_W'(zi_ff);
      end
      if (cmd.update) begin
         zr_ff    <= zr_in;
         zi_ff    <= zi_in;
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.escape) begin
         esc_ff <= 1'b1;
      end
      if (cmd.emit) begin
         out_col_ff <= col_ff;
         out_row_ff <= row_ff;
         out_cnt_ff <= count_ff;
         out_esc_ff <= esc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_esc_ff, out_cnt_ff, out_row_ff, out_col_ff};

   `ASSERT_IMPLY(a_mul_below_limit, clock, reset, cmd.mul, count_ff < cfg.max_iter)
   `ASSERT_IMPLY(a_update_not_escaped, clock, reset, cmd.update, !sts.escape_hit)
   `ASSERT_IMPLY(a_emit_escape_count, clock, reset, cmd.emit && esc_ff, count_ff < cfg.max_iter)
   `ASSERT_NEXT(a_emit_shows_beat, clock, reset, cmd.emit, rsp_valid_ff)

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mandelbrot_escape_time_unit. It streams pixel beats
// under random source gaps and sink stalls. It predicts each pixel's iteration
// count and escape flag from its own copy of the plane registers, and checks
// every result beat in order. Directed cases come first: corners, zero limit,
// escape on the limit, register extremes and dropped indexes. Random planes
// near the set and random noise planes follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import mbrot_pkg::*;

   typedef struct packed {
      logic             pad;
      logic             escaped;
      logic [CRD_W-1:0] iter_count;
      logic [CRD_W-1:0] out_row;
      logic [CRD_W-1:0] out_col;
   } pixel_result_t;

   localparam logic [PROD_W-1:0] ESCAPE_RADIUS_SQ = 64'd4 << (2 * FRAC_BITS);
   localparam logic [FIX_W-1:0]  TWO_FIX          = 32'd2 << FRAC_BITS;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_index  = '0;
   logic [FIX_W-1:0] csr_data   = '0;

   cfg_type plane_cfg = '{min_re: 32'hE000_0000, min_im: 32'hECCC_CCCD,
                          step_re: 32'h000C_0000, step_im: 32'h0009_999A,
                          max_iter: 10'd50};

   pixel_result_t due_pixels[$];
   int unsigned   mismatch_count = 0;
   bit            steady         = 1'b0;
   int unsigned   rsp_hold       = 0;

   mandelbrot_escape_time_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #500_000_000;
      $display("FAILURE");
      $finish;
   end

   // Iterate z = z*z + c from zero in Q4.28; the escape test precedes each step.
   function automatic pixel_result_t escape_time_of(input logic [CRD_W-1:0] col,
                                                    input logic [CRD_W-1:0] row);
      pixel_result_t      res;
      logic [FIX_W-1:0]   cr, ci, zr, zi;
      logic signed [63:0] rr, ii, ri;
      logic [PROD_W-1:0]  mag;
      int unsigned        count;
      logic               esc;
      cr    = plane_cfg.min_re + plane_cfg.step_re * {22'd0, col};
      ci    = plane_cfg.min_im + plane_cfg.step_im * {22'd0, row};
      zr    = '0;
      zi    = '0;
      count = 0;
      esc   = 1'b0;
      while (count < plane_cfg.max_iter && !esc) begin
         rr  = PROD_W'($signed(zr)) * PROD_W'($signed(zr));
         ii  = PROD_W'($signed(zi)) * PROD_W'($signed(zi));
         ri  = PROD_W'($signed(zr)) * PROD_W'($signed(zi));
         mag = rr + ii;
         if (mag >= ESCAPE_RADIUS_SQ) begin
            esc = 1'b1;
         end else begin
            zr = rr[59:28] - ii[59:28] + cr;
            zi = ri[58:27] + ci;
            count++;
         end
      end
      res.pad        = 1'b0;
      res.escaped    = esc;
      res.iter_count = count[CRD_W-1:0];
      res.out_row    = row;
      res.out_col    = col;
      return res;
   endfunction

   // Mostly no gap, some short ones and now and then a long one.
   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (due_pixels.size() == 0) begin
            $display("%0t: result beat with nothing pending, expected none, actual %h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = due_pixels.pop_front();
            check_field("out_col", 32'(want.out_col), 32'(got.out_col));
            check_field("out_row", 32'(want.out_row), 32'(got.out_row));
            check_field("iter_count", 32'(want.iter_count), 32'(got.iter_count));
            check_field("escaped", 32'(want.escaped), 32'(got.escaped));
            check_field("pad", 32'(want.pad), 32'(got.pad));
         end
      end
   end

   // Sink pacing: a requested hold-off wins over the random stalls.
   initial begin : rsp_pacing
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end else if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = idle_span();
            rsp_tready <= (stall_left == 0);
            if (stall_left != 0) stall_left--;
         end
      end
   end

   task automatic write_csr(input logic [IDX_W-1:0] index, input logic [FIX_W-1:0] value,
                            input bit last_beat);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (last_beat) csr_valid <= 1'b0;
      case (index)
         CSR_MIN_RE:   plane_cfg.min_re   = value;
         CSR_MIN_IM:   plane_cfg.min_im   = value;
         CSR_STEP_RE:  plane_cfg.step_re  = value;
         CSR_STEP_IM:  plane_cfg.step_im  = value;
         CSR_MAX_ITER: plane_cfg.max_iter = value[CRD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_view(input logic [FIX_W-1:0] min_re, input logic [FIX_W-1:0] min_im,
                               input logic [FIX_W-1:0] step_re, input logic [FIX_W-1:0] step_im,
                               input logic [FIX_W-1:0] limit_word);
      write_csr(CSR_MIN_RE, min_re, 1'b0);
      write_csr(CSR_MIN_IM, min_im, 1'b0);
      write_csr(CSR_STEP_RE, step_re, 1'b0);
      write_csr(CSR_STEP_IM, step_im, 1'b0);
      write_csr(CSR_MAX_ITER, limit_word, 1'b1);
   endtask

   // Keep tvalid high across back-to-back beats; drop it only for a gap.
   task automatic send_pixel(input logic [CRD_W-1:0] col, input logic [CRD_W-1:0] row);
      int unsigned gap;
      gap = idle_span();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(REQ_W - 2 * CRD_W){1'b0}}, row, col};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      due_pixels.push_back(escape_time_of(col, row));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_pixels.size() != 0);
   endtask

   task automatic test_reset_view();
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd341, 10'd682);
      wait_for_results();
   endtask

   task automatic test_zero_limit();
      program_view(32'hE000_0000, 32'hECCC_CCCD, 32'h000C_0000, 32'h0009_999A, 32'd0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd700, 10'd512);
      wait_for_results();
   endtask

   // c = 2 reaches |z|^2 = 4 after one step: the limit wins at one, not at two.
   task automatic test_limit_wins_escape();
      program_view(TWO_FIX, 32'd0, 32'd0, 32'd0, 32'd1);
      send_pixel(10'd5, 10'd9);
      wait_for_results();
      write_csr(CSR_MAX_ITER, 32'd2, 1'b1);
      send_pixel(10'd1023, 10'd0);
      wait_for_results();
   endtask

   task automatic test_register_extremes();
      program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1, 10'd1023);
      wait_for_results();
      // c = 0 never escapes: runs the full limit
      program_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd1023);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      wait_for_results();
   endtask

   task automatic test_ignored_index();
      int last_index;
      last_index = 2 ** IDX_W - 1;
      for (int k = int'(CSR_MAX_ITER) + 1; k <= last_index; k++)
         write_csr(k[IDX_W-1:0], $urandom, k == last_index);
      repeat (3) send_pixel(CRD_W'($urandom_range(0, 1023)), CRD_W'($urandom_range(0, 1023)));
      wait_for_results();
   endtask

   // Random plane around the set; a stream of pixels, some stepping along the row, most drawn at random.
   task automatic run_region_phase(input int unsigned items, input logic [FIX_W-1:0] limit_word);
      logic [FIX_W-1:0] step_re, step_im;
      logic [CRD_W-1:0] col, row;
      step_re = $urandom_range(0, 1 << 20);
      step_im = $urandom_range(0, 1 << 20);
      if ($urandom_range(0, 1)) step_re = -step_re;
      if ($urandom_range(0, 1)) step_im = -step_im;
      program_view(32'd0 - $urandom_range(0, 671088640), 32'd0 - $urandom_range(0, 402653184),
                   step_re, step_im, limit_word);
      col = CRD_W'($urandom_range(0, 1023));
      row = CRD_W'($urandom_range(0, 1023));
      repeat (items) begin
         if ($urandom_range(0, 9) < 4) begin
            col = col + 1'b1;
         end else begin
            col = CRD_W'($urandom_range(0, 1023));
            row = CRD_W'($urandom_range(0, 1023));
         end
         send_pixel(col, row);
         if ($urandom_range(0, 49) == 0) wait_for_results();
      end
      wait_for_results();
   endtask

   task automatic test_output_backpressure();
      steady   = 1'b1;
      rsp_hold = 400;
      run_region_phase(24, 32'd20);
      steady   = 1'b0;
   endtask

   task automatic test_random_regions();
      for (int phase = 0; phase < 10; phase++) begin
         steady = (phase % 4 == 3);
         run_region_phase(105, $urandom_range(1, 64));
      end
      steady = 1'b0;
      run_region_phase(8, 32'd1023);
   endtask

   task automatic test_random_noise();
      repeat (3) begin
         program_view($urandom, $urandom, $urandom, $urandom, $urandom);
         repeat (50) send_pixel(CRD_W'($urandom_range(0, 1023)), CRD_W'($urandom_range(0, 1023)));
         wait_for_results();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_view();
      test_zero_limit();
      test_limit_wins_escape();
      test_register_extremes();
      test_ignored_index();
      test_output_backpressure();
      test_random_regions();
      test_random_noise();
      // let any stray beat show up before the verdict
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/mbrot_pkg.sv
design/mbrot_ctrl.sv
design/mbrot_dpath.sv
design/mandelbrot_escape_time_unit.sv
test/testbench.sv
